### src/btsw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btsw_pkg
// shared constants of the bilinear texture sampler
// ----------------------------------------------------------------------------
package btsw_pkg;
  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;
  localparam logic [0:0] REG_TEX_WIDTH  = 1'd0;
  localparam logic [0:0] REG_TEX_HEIGHT = 1'd1;
  localparam int CFG_BITS   = 9;
  localparam int FRAC_BITS  = 16;
  localparam int FIELD_BITS = 16;
endpackage

### src/bilinear_texture_sampler_wrap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_wrap
// texel store with wrapped bilinear sampling
// ----------------------------------------------------------------------------
// Usage: input words arrive on in_valid / in_stall. A word with kind 0 writes
// one RGB texel into the store (if it lies inside the texture size) and
// gives no result; kind 1 samples the texture at (coord_u, coord_v), wrapped
// with period one, and gives one RGB result word on out_valid / out_stall.
// Writes can follow back to back. A sample passes from acceptance to the
// result register through these steps: split the coordinates, read the four
// neighbors (the single read port fetches one neighbor per cycle, and its
// read data is registered), blend in x, blend in y, and load the result
// register. The input is stalled for the whole sample, so a new word is
// taken only after the sample has loaded its result register.
// The result register frees the input side while a result waits, but a
// sample waits for the result register to be empty before completing.
// Reset clears control state and sets both texture sizes to 256; the texel
// store has no reset and must be written before it is sampled. A stalled
// result holds steady until taken.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_wrap
  import btsw_pkg::*;
#(
  parameter int SIZE_BITS    = 8,
  parameter int CHANNEL_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic [7:0]            texel_col,
  input  logic [7:0]            texel_row,
  input  logic [15:0]           write_red,
  input  logic [15:0]           write_green,
  input  logic [15:0]           write_blue,
  input  logic signed [31:0]    coord_u,
  input  logic signed [31:0]    coord_v,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           out_red,
  output logic [15:0]           out_green,
  output logic [15:0]           out_blue
);
  localparam int SIDE   = 1 << SIZE_BITS;
  localparam int AW     = 2 * SIZE_BITS;
  localparam int DEPTH  = 1 << AW;
  localparam int TW     = 3 * CHANNEL_BITS;
  localparam int SZW    = SIZE_BITS + 1;
  localparam int PW     = CHANNEL_BITS + FRAC_BITS + 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SPLIT = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_BX    = 3'd3;
  localparam logic [2:0] ST_BY    = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [TW-1:0] store [DEPTH];
  logic [TW-1:0] rd_data;
  logic [AW-1:0] rd_addr;

  logic [SZW-1:0] tex_width, tex_height;
  logic [2:0] state;
  logic [2:0] rd_cnt;
  logic [2:0] got_cnt;
  logic [FRAC_BITS-1:0] fu, fv;
  logic [SIZE_BITS-1:0] x0, y0;
  logic [FRAC_BITS:0] wx, wy;
  logic [TW-1:0] t00, t10, t01, t11;
  logic [CHANNEL_BITS-1:0] top [3];
  logic [CHANNEL_BITS-1:0] bot [3];
  logic [CHANNEL_BITS-1:0] res [3];

  function automatic logic [SZW-1:0] clamp_size(input logic [CFG_BITS-1:0] v);
    logic [SZW-1:0] r;
    if (v < CFG_BITS'(2)) r = SZW'(2);
    else if (int'(v) > SIDE) r = SZW'(SIDE);
    else r = SZW'(v);
    return r;
  endfunction

  function automatic logic [CHANNEL_BITS-1:0] blend(input logic [CHANNEL_BITS-1:0] a,
      input logic [CHANNEL_BITS-1:0] b, input logic [FRAC_BITS:0] w);
    logic [PW:0] s;
    s = (PW+1)'(a) * (PW+1)'((FRAC_BITS+1)'(1 << FRAC_BITS) - w) + (PW+1)'(b) * (PW+1)'(w);
    return CHANNEL_BITS'(s >> FRAC_BITS);
  endfunction

  // wrap and scale one coordinate: base index and weight
  function automatic logic [SIZE_BITS+FRAC_BITS:0] split(input logic [FRAC_BITS-1:0] f,
      input logic [SZW-1:0] size);
    logic [FRAC_BITS+SZW-1:0] sc;
    logic [SZW-1:0] i0;
    logic [FRAC_BITS+SZW-1:0] wt;
    sc = (FRAC_BITS+SZW)'(f) * (FRAC_BITS+SZW)'(size - SZW'(1));
    i0 = sc[FRAC_BITS+SZW-1:FRAC_BITS];
    if (i0 > size - SZW'(2)) i0 = size - SZW'(2);
    wt = sc - ((FRAC_BITS+SZW)'(i0) << FRAC_BITS);
    return {i0[SIZE_BITS-1:0], wt[FRAC_BITS:0]};
  endfunction

  logic in_fire, out_fire, wr_ok;
  logic [SIZE_BITS+FRAC_BITS:0] su, sv;
  logic [SIZE_BITS-1:0] x1, y1;

  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign wr_ok    = (SZW'(texel_col) < tex_width) && (SZW'(texel_row) < tex_height)
                    && (texel_col < 8'(SIDE - 1) || SIDE >= 256 || texel_col == 8'(SIDE - 1))
                    && (texel_row < 8'(SIDE - 1) || SIDE >= 256 || texel_row == 8'(SIDE - 1));
  assign su = split(fu, tex_width);
  assign sv = split(fv, tex_height);
  assign x1 = x0 + SIZE_BITS'(1);
  assign y1 = y0 + SIZE_BITS'(1);

  always_comb begin
    case (rd_cnt[1:0])
      2'd0: rd_addr = {y0, x0};
      2'd1: rd_addr = {y0, x1};
      2'd2: rd_addr = {y1, x0};
      default: rd_addr = {y1, x1};
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire && kind == KIND_WRITE && wr_ok) begin
      store[{SIZE_BITS'(texel_row), SIZE_BITS'(texel_col)}] <=
        {CHANNEL_BITS'(write_red), CHANNEL_BITS'(write_green), CHANNEL_BITS'(write_blue)};
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width  <= SZW'(SIDE);
      tex_height <= SZW'(SIDE);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEX_WIDTH:  tex_width  <= clamp_size(cfg_data);
        REG_TEX_HEIGHT: tex_height <= clamp_size(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rd_cnt    <= '0;
      got_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_fire && state != ST_OUT) out_valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (in_fire && kind == KIND_SAMPLE) begin
            fu    <= coord_u[FRAC_BITS-1:0];
            fv    <= coord_v[FRAC_BITS-1:0];
            state <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          x0      <= su[SIZE_BITS+FRAC_BITS:FRAC_BITS+1];
          wx      <= su[FRAC_BITS:0];
          y0      <= sv[SIZE_BITS+FRAC_BITS:FRAC_BITS+1];
          wy      <= sv[FRAC_BITS:0];
          rd_cnt  <= '0;
          got_cnt <= '0;
          state   <= ST_READ;
        end
        ST_READ: begin
          if (rd_cnt != 3'd4) rd_cnt <= rd_cnt + 3'd1;
          if (rd_cnt != 3'd0) begin
            got_cnt <= got_cnt + 3'd1;
            case (got_cnt[1:0])
              2'd0: t00 <= rd_data;
              2'd1: t10 <= rd_data;
              2'd2: t01 <= rd_data;
              default: t11 <= rd_data;
            endcase
            if (got_cnt == 3'd3) state <= ST_BX;
          end
        end
        ST_BX: begin
          for (int c = 0; c < 3; c++) begin
            top[c] <= blend(t00[c*CHANNEL_BITS +: CHANNEL_BITS],
                            t10[c*CHANNEL_BITS +: CHANNEL_BITS], wx);
            bot[c] <= blend(t01[c*CHANNEL_BITS +: CHANNEL_BITS],
                            t11[c*CHANNEL_BITS +: CHANNEL_BITS], wx);
          end
          state <= ST_BY;
        end
        ST_BY: begin
          for (int c = 0; c < 3; c++) res[c] <= blend(top[c], bot[c], wy);
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || out_fire) begin
            out_red   <= FIELD_BITS'(res[2]);
            out_green <= FIELD_BITS'(res[1]);
            out_blue  <= FIELD_BITS'(res[0]);
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// randomized check of the wrapped bilinear texture sampler
// ----------------------------------------------------------------------------
// Texels are loaded first, then samples are sent whose four neighbors are all
// loaded. Each accepted word is run through a local texel store and blend
// predictor, and every result word is compared against the oldest prediction.
// Texture sizes change between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import btsw_pkg::*;

  typedef struct {
    logic        kind;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [31:0] u;
    logic [31:0] v;
  } word_t;

  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } rgb_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [0:0] cfg_index = REG_TEX_WIDTH;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic kind = 0;
  logic [7:0] texel_col = 0, texel_row = 0;
  logic [15:0] write_red = 0, write_green = 0, write_blue = 0;
  logic signed [31:0] coord_u = 0, coord_v = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [15:0] out_red, out_green, out_blue;

  bilinear_texture_sampler_wrap uut (.*);

  always #10 clk = ~clk;

  word_t pending_words[$];
  rgb_t  expected_rgb[$];
  logic [47:0] texel_mem [0:65535];
  int unsigned model_w = 256, model_h = 256;
  int errors = 0;

  function automatic int unsigned clamp_size(logic [8:0] v);
    if (v < 2) return 2;
    if (v > 256) return 256;
    return 32'(v);
  endfunction

  function automatic void split(logic [31:0] raw, int unsigned size,
                                output int unsigned base, output int unsigned wt);
    longint unsigned scaled;
    scaled = longint'(raw[15:0]) * (size - 1);
    base = 32'(scaled >> 16);
    if (base > size - 2) base = size - 2;
    wt = 32'(scaled - (longint'(base) << 16));
  endfunction

  function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b, int unsigned wt);
    longint unsigned s;
    s = longint'(a) * (65536 - wt) + longint'(b) * wt;
    return s[31:16];
  endfunction

  function automatic void predict_word(word_t w);
    int unsigned x0, wx, y0, wy;
    logic [47:0] t00, t10, t01, t11;
    logic [15:0] top, bot;
    rgb_t r;
    if (w.kind == KIND_WRITE) begin
      if (w.col < model_w && w.row < model_h)
        texel_mem[{w.row, w.col}] = {w.red, w.green, w.blue};
      return;
    end
    split(w.u, model_w, x0, wx);
    split(w.v, model_h, y0, wy);
    t00 = texel_mem[{y0[7:0], x0[7:0]}];
    t10 = texel_mem[{y0[7:0], 8'(x0 + 1)}];
    t01 = texel_mem[{8'(y0 + 1), x0[7:0]}];
    t11 = texel_mem[{8'(y0 + 1), 8'(x0 + 1)}];
    for (int c = 0; c < 3; c++) begin
      top = blend(t00[47-16*c -: 16], t10[47-16*c -: 16], wx);
      bot = blend(t01[47-16*c -: 16], t11[47-16*c -: 16], wx);
      case (c)
        0: r.red = blend(top, bot, wy);
        1: r.green = blend(top, bot, wy);
        default: r.blue = blend(top, bot, wy);
      endcase
    end
    expected_rgb.push_back(r);
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // input driver
  word_t cur;
  int gap_cnt = 0, burst_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) predict_word(cur);
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        in_valid <= 0;
      end else if (pending_words.size() > 0) begin
        cur = pending_words.pop_front();
        kind <= cur.kind;
        texel_col <= cur.col;
        texel_row <= cur.row;
        write_red <= cur.red;
        write_green <= cur.green;
        write_blue <= cur.blue;
        coord_u <= cur.u;
        coord_v <= cur.v;
        in_valid <= 1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
          gap_cnt <= 0;
        end else begin
          gap_cnt <= $urandom_range(0, 6);
          if ($urandom_range(0, 19) == 0) burst_left <= 30;
        end
      end else begin
        in_valid <= 0;
      end
    end
  end

  // result monitor
  int stall_cnt = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rgb.size() == 0) begin
          $display("result word with nothing expected at %0t", $realtime);
          errors++;
        end else begin
          rgb_t e;
          e = expected_rgb.pop_front();
          if (out_red !== e.red) report("red", out_red, e.red);
          if (out_green !== e.green) report("green", out_green, e.green);
          if (out_blue !== e.blue) report("blue", out_blue, e.blue);
        end
        stall_cnt = (burst_left > 0) ? 0 : $urandom_range(0, 6);
      end
      if (stall_cnt > 0) begin
        out_stall <= 1;
        stall_cnt--;
      end else begin
        out_stall <= 0;
      end
    end
  end

  function automatic logic [15:0] chan_val();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic word_t write_word(int unsigned col, int unsigned row);
    word_t w;
    w.kind = KIND_WRITE;
    w.col = 8'(col);
    w.row = 8'(row);
    w.red = chan_val();
    w.green = chan_val();
    w.blue = chan_val();
    w.u = $urandom;
    w.v = $urandom;
    return w;
  endfunction

  // small sizes are filled completely, large ones only near both edges
  task automatic load_texture(int unsigned w, int unsigned h);
    for (int unsigned r = 0; r < h; r++)
      for (int unsigned c = 0; c < w; c++)
        if (!((h > 16 && r >= 4 && r < h - 4) || (w > 16 && c >= 4 && c < w - 4)))
          pending_words.push_back(write_word(c, r));
  endtask

  function automatic logic [15:0] safe_frac(int unsigned size);
    int unsigned lim;
    if (size <= 16) return 16'($urandom);
    lim = 2 * 65536 / (size - 1);
    if ($urandom_range(0, 1)) return 16'($urandom_range(0, lim));
    return 16'hffff - 16'($urandom_range(0, lim));
  endfunction

  task automatic push_sample(int unsigned w, int unsigned h);
    word_t s;
    s = write_word($urandom_range(0, 255), $urandom_range(0, 255));
    s.kind = KIND_SAMPLE;
    s.u[15:0] = safe_frac(w);
    s.v[15:0] = safe_frac(h);
    pending_words.push_back(s);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_words.size() > 0 || in_valid || expected_rgb.size() > 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [8:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == REG_TEX_WIDTH) model_w = clamp_size(val);
    else model_h = clamp_size(val);
  endtask

  task automatic run_phase(int samples);
    int unsigned w, h;
    word_t x;
    w = model_w;
    h = model_h;
    load_texture(w, h);
    for (int i = 0; i < samples; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        x = write_word($urandom_range(0, 255), $urandom_range(0, 255));
        // shift writes aimed at the unloaded middle of a large texture by the width
        if ((w > 16 && x.col >= 4 && x.col < w - 4) || (h > 16 && x.row >= 4 && x.row < h - 4)) begin
          x.col = 8'(x.col + w);
        end
        pending_words.push_back(x);
      end
      push_sample(w, h);
    end
    wait_idle();
  endtask

  initial begin
    logic [15:0] lo [4];
    logic [15:0] hi [4];
    word_t s;
    logic [8:0] wl [10];
    logic [8:0] hl [10];
    lo = '{16'h0000, 16'h0001, 16'hfffe, 16'hffff};
    hi = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    wl = '{9'd2, 9'd0, 9'd511, 9'd3, 9'd256, 9'd2, 9'd9, 9'd17, 9'd1, 9'd300};
    hl = '{9'd2, 9'd1, 9'd300, 9'd5, 9'd2, 9'd256, 9'd16, 9'd100, 9'd0, 9'd511};
    repeat (8) @(posedge clk);
    rst <= 0;
    // reset sizes, edge coordinates
    load_texture(256, 256);
    for (int i = 0; i < 16; i++) begin
      s = write_word(0, 0);
      s.kind = KIND_SAMPLE;
      s.u = {hi[i / 4], lo[i % 4]};
      s.v = {hi[i % 4], lo[(i + 1) % 4]};
      pending_words.push_back(s);
    end
    wait_idle();
    run_phase(40);
    for (int p = 0; p < 10; p++) begin
      write_reg(REG_TEX_WIDTH, wl[p]);
      write_reg(REG_TEX_HEIGHT, hl[p]);
      run_phase(50);
    end
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_TEX_WIDTH, 9'($urandom_range(2, 16)));
      write_reg(REG_TEX_HEIGHT, 9'($urandom_range(2, 16)));
      run_phase(40);
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_rgb.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

### bilinear_texture_sampler_wrap.f
src/btsw_pkg.sv
src/bilinear_texture_sampler_wrap.sv
sim/testbench.sv
